// File: sv/pstp_pkg.sv
`timescale 1ns / 1ps

package pstp_pkg;

  // Geometry and scan limits.
  localparam int IMAGE_SIZE    = 500;
  localparam int BEAM_COUNT    = 4096;
  localparam int CORDIC_STAGES = 16;

  // Field and port widths.
  localparam int RANGE_W  = 16;
  localparam int INDEX_W  = 12;
  localparam int ANGLE_W  = 16;
  localparam int SCALE_W  = 24;
  localparam int PIX_W    = 9;
  localparam int IN_DW    = 32;
  localparam int OUT_DW   = 24;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 24;
  localparam int RS_W     = RANGE_W + SCALE_W;

  // Datapath widths: CORDIC in Q2.30 with headroom, trig in Q.20.
  localparam int CW       = 34;
  localparam int TRIG_W   = 25;
  localparam int HALF_W   = RS_W / 2;
  localparam int PP_W     = HALF_W + 1 + TRIG_W;
  localparam int SUM_W    = 66;
  localparam int QUOT_W   = SUM_W - 36;
  localparam int COORD_W  = QUOT_W + 1;

  localparam logic signed [CW-1:0]    GAIN_Q30   = 34'sd652032874;
  localparam logic signed [CW-1:0]    ROUND_HALF = 34'sd512;
  localparam logic signed [SUM_W-1:0] TRUNC_BIAS = (66'sd1 <<< 36) - 66'sd1;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = QUEUE_AW + 1;

  // Configuration register indexes.
  typedef enum logic [CFG_AW-1:0] {
    CFG_RANGE_MIN   = 3'd0,
    CFG_RANGE_MAX   = 3'd1,
    CFG_ANGLE_START = 3'd2,
    CFG_ANGLE_STEP  = 3'd3,
    CFG_PIXEL_SCALE = 3'd4
  } cfg_idx_t;

  // One classified item as it leaves the front.
  typedef struct packed {
    logic [RS_W-1:0]           rs;
    logic signed [ANGLE_W-1:0] angle;
    logic                      neg;
    logic                      gate;
    logic                      last;
  } work_t;

  // Side data that rides along the back pipeline.
  typedef struct packed {
    logic [RS_W-1:0] rs;
    logic            neg;
    logic            gate;
    logic            last;
  } meta_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic [QUEUE_CW-1:0] count;
    logic                full;
    logic                empty;
  } queue_stat_t;

  // Arctangent of 2^-i as a fraction of a turn scaled by 2^32.
  function automatic logic signed [CW-1:0] atan_entry(input int i);
    logic signed [CW-1:0] r;
    case (i)
      0:  r = 34'sh20000000;
      1:  r = 34'sh12E4051E;
      2:  r = 34'sh09FB385B;
      3:  r = 34'sh051111D4;
      4:  r = 34'sh028B0D43;
      5:  r = 34'sh0145D7E1;
      6:  r = 34'sh00A2F61E;
      7:  r = 34'sh00517C55;
      8:  r = 34'sh0028BE53;
      9:  r = 34'sh00145F2F;
      10: r = 34'sh000A2F98;
      11: r = 34'sh000517CC;
      12: r = 34'sh00028BE6;
      13: r = 34'sh000145F3;
      14: r = 34'sh0000A2F9;
      15: r = 34'sh0000517C;
      16: r = 34'sh000028BE;
      17: r = 34'sh0000145F;
      18: r = 34'sh00000A2F;
      19: r = 34'sh00000517;
      20: r = 34'sh0000028B;
      21: r = 34'sh00000145;
      22: r = 34'sh000000A2;
      23: r = 34'sh00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/pstp_front.sv
`timescale 1ns / 1ps

module pstp_front import pstp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // Configuration writes
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  // Sample stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,  // range_mm[15:0], beam_index[27:16], zero pad
  input  logic              in_tlast,
  // Queue side
  input  queue_stat_t       q_stat,
  output logic              push,
  output work_t             push_item
);

  logic [RANGE_W-1:0] range_min_r, range_max_r;
  logic [ANGLE_W-1:0] angle_start_r, angle_step_r;
  logic [SCALE_W-1:0] pixel_scale_r;

  logic               s1_v_r, s1_v_nxt;
  logic [RS_W-1:0]    rs_r;
  logic [ANGLE_W-1:0] prod_r;
  logic               gate_r, last_r;

  logic [RANGE_W-1:0] in_range;
  logic [INDEX_W-1:0] in_index;
  logic               accept;
  logic [ANGLE_W-1:0] theta;
  logic signed [ANGLE_W-1:0] theta_s;
  logic               fold;

  assign in_range = in_tdata[RANGE_W-1:0];
  assign in_index = in_tdata[RANGE_W +: INDEX_W];

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r   <= '0;
      range_max_r   <= 16'hFFFF;
      angle_start_r <= '0;
      angle_step_r  <= '0;
      pixel_scale_r <= 24'd1365;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_RANGE_MIN:   range_min_r   <= cfg_wdata[RANGE_W-1:0];
        CFG_RANGE_MAX:   range_max_r   <= cfg_wdata[RANGE_W-1:0];
        CFG_ANGLE_START: angle_start_r <= cfg_wdata[ANGLE_W-1:0];
        CFG_ANGLE_STEP:  angle_step_r  <= cfg_wdata[ANGLE_W-1:0];
        CFG_PIXEL_SCALE: pixel_scale_r <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // The input stage frees up whenever its item moves into the queue.
  assign push      = s1_v_r && !q_stat.full;
  assign in_tready = !s1_v_r || push;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (push) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  // Range gate, range times scale, and the low bits of index times step.
  always_ff @(posedge clk) begin
    if (accept) begin
      rs_r   <= {{SCALE_W{1'b0}}, in_range} * {{RANGE_W{1'b0}}, pixel_scale_r};
      prod_r <= ANGLE_W'({{ANGLE_W{1'b0}}, in_index} * {{INDEX_W{1'b0}}, angle_step_r});
      gate_r <= (in_range > range_min_r) && (in_range < range_max_r) &&
                (32'(in_index) < BEAM_COUNT);
      last_r <= in_tlast;
    end
  end

  // Beam angle wraps mod a full turn, then folds into the right half plane.
  // Removing a half turn only flips the sign bit of a binary angle.
  assign theta   = angle_start_r + prod_r;
  assign theta_s = signed'(theta);
  assign fold    = (theta_s > 16'sd16384) || (theta_s < -16'sd16384);

  always_comb begin
    push_item.rs    = rs_r;
    push_item.angle = fold ? signed'({~theta[ANGLE_W-1], theta[ANGLE_W-2:0]}) : theta_s;
    push_item.neg   = fold;
    push_item.gate  = gate_r;
    push_item.last  = last_r;
  end

endmodule

// File: sv/pstp_queue.sv
`timescale 1ns / 1ps

module pstp_queue import pstp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  work_t       push_item,
  input  logic        pop,
  output work_t       head,
  output queue_stat_t stat
);

  work_t               mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r, count_nxt;

  assign stat.count = count_r;
  assign stat.full  = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head       = mem_r[rd_ptr_r];

  // Occupancy tracks pushes and pops that may land in the same cycle.
  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: sv/pstp_back.sv
`timescale 1ns / 1ps

module pstp_back import pstp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  queue_stat_t       q_stat,
  input  work_t             q_head,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // pixel_x[8:0], pixel_y[17:9], zero pad
  output logic              out_tlast,
  output logic              out_tuser   // hit
);

  // Element 0 is the load stage, element i the result of rotation i-1.
  logic                 cv_r [0:CORDIC_STAGES];
  logic signed [CW-1:0] cx_r [0:CORDIC_STAGES];
  logic signed [CW-1:0] cy_r [0:CORDIC_STAGES];
  logic signed [CW-1:0] cz_r [0:CORDIC_STAGES];
  meta_t                cm_r [0:CORDIC_STAGES];

  logic                     rv_r, pv_r, sv_r, ov_r;
  meta_t                    rm_r, pm_r, sm_r;
  logic signed [TRIG_W-1:0] cos_r, sin_r;
  logic signed [PP_W-1:0]   pxl_r, pxh_r, pyl_r, pyh_r;
  logic signed [SUM_W-1:0]  sx_r, sy_r;
  logic [PIX_W-1:0]         px_r, py_r;
  logic                     hit_r, last_r;

  logic                     en;
  logic signed [CW-1:0]     xn, yn;
  logic signed [QUOT_W-1:0] qx, qy;
  logic signed [COORD_W-1:0] xi, yi;
  logic                     hit_nxt;

  // The whole back pipeline advances when the output register can take an item.
  assign en  = !ov_r || out_tready;
  assign pop = en && !q_stat.empty;

  // Load stage: unit vector times the CORDIC gain, angle as a 2^32 turn.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (en) begin
      cv_r[0] <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0]      <= GAIN_Q30;
      cy_r[0]      <= '0;
      cz_r[0]      <= CW'(signed'({q_head.angle, 16'h0000}));
      cm_r[0].rs   <= q_head.rs;
      cm_r[0].neg  <= q_head.neg;
      cm_r[0].gate <= q_head.gate;
      cm_r[0].last <= q_head.last;
    end
  end

  // One rotation per stage, direction from the sign of the residual angle.
  for (genvar i = 1; i <= CORDIC_STAGES; i++) begin : g_rot
    logic signed [CW-1:0] xs, ys, x_nxt, y_nxt, z_nxt;

    assign xs = cx_r[i-1] >>> (i - 1);
    assign ys = cy_r[i-1] >>> (i - 1);

    always_comb begin
      if (!cz_r[i-1][CW-1]) begin
        x_nxt = cx_r[i-1] - ys;
        y_nxt = cy_r[i-1] + xs;
        z_nxt = cz_r[i-1] - atan_entry(i - 1);
      end else begin
        x_nxt = cx_r[i-1] + ys;
        y_nxt = cy_r[i-1] - xs;
        z_nxt = cz_r[i-1] + atan_entry(i - 1);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i] <= 1'b0;
      end else if (en) begin
        cv_r[i] <= cv_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cx_r[i] <= x_nxt;
        cy_r[i] <= y_nxt;
        cz_r[i] <= z_nxt;
        cm_r[i] <= cm_r[i-1];
      end
    end
  end

  // Undo the half-turn fold, then round Q2.30 to Q.20.
  assign xn = cm_r[CORDIC_STAGES].neg ? -cx_r[CORDIC_STAGES] : cx_r[CORDIC_STAGES];
  assign yn = cm_r[CORDIC_STAGES].neg ? -cy_r[CORDIC_STAGES] : cy_r[CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= TRIG_W'((xn + ROUND_HALF) >>> 10);
      sin_r <= TRIG_W'((yn + ROUND_HALF) >>> 10);
      rm_r  <= cm_r[CORDIC_STAGES];
    end
  end

  // Range-scale product split in halves so each multiplier stays narrow.
  always_ff @(posedge clk) begin
    if (en) begin
      pxl_r <= signed'({1'b0, rm_r.rs[HALF_W-1:0]}) * cos_r;
      pxh_r <= signed'({1'b0, rm_r.rs[RS_W-1:HALF_W]}) * cos_r;
      pyl_r <= signed'({1'b0, rm_r.rs[HALF_W-1:0]}) * sin_r;
      pyh_r <= signed'({1'b0, rm_r.rs[RS_W-1:HALF_W]}) * sin_r;
      pm_r  <= rm_r;
    end
  end

  // Recombine the partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      sx_r <= (SUM_W'(pxh_r) <<< HALF_W) + SUM_W'(pxl_r);
      sy_r <= (SUM_W'(pyh_r) <<< HALF_W) + SUM_W'(pyl_r);
      sm_r <= pm_r;
    end
  end

  // Divide by 2^36 toward zero, center on the image, and bounds check.
  assign qx = QUOT_W'((sx_r + (sx_r[SUM_W-1] ? TRUNC_BIAS : '0)) >>> 36);
  assign qy = QUOT_W'((sy_r + (sy_r[SUM_W-1] ? TRUNC_BIAS : '0)) >>> 36);
  assign xi = COORD_W'(qx) + COORD_W'(IMAGE_SIZE / 2);
  assign yi = COORD_W'(qy) + COORD_W'(IMAGE_SIZE / 2);
  assign hit_nxt = sm_r.gate &&
                   (xi >= 0) && (xi < COORD_W'(IMAGE_SIZE)) &&
                   (yi >= 0) && (yi < COORD_W'(IMAGE_SIZE));

  // Valid bits of the middle stages and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
      pv_r <= 1'b0;
      sv_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      rv_r <= cv_r[CORDIC_STAGES];
      pv_r <= rv_r;
      sv_r <= pv_r;
      ov_r <= sv_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= hit_nxt ? xi[PIX_W-1:0] : '0;
      py_r   <= hit_nxt ? yi[PIX_W-1:0] : '0;
      hit_r  <= hit_nxt;
      last_r <= sm_r.last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {(OUT_DW - 2 * PIX_W)'(0), py_r, px_r};
  assign out_tuser  = hit_r;
  assign out_tlast  = last_r;

endmodule

// File: sv/polar_scan_to_pixel_core.sv
`timescale 1ns / 1ps

// Projects lidar range samples onto a square pixel grid, one sample per clock
// in steady state while the output takes results. A sample enters an input
// stage that applies the range gate, forms range times pixel scale and the
// beam angle, then waits in a four-entry queue. The back pipeline has a load
// stage, one stage per CORDIC rotation, rounding, split multiply, recombine
// and an output register. Every sample yields exactly one result; hit in tuser
// is low, with both coordinates zero, for gated or off-image samples. Both
// sides stall independently: output backpressure freezes the back pipeline
// and fills the queue before the input stage stops taking samples.
module polar_scan_to_pixel_core import pstp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // Configuration writes
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  // Sample stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // range_mm[15:0], beam_index[27:16], zero pad
  input  logic              in_tlast,   // last_beam
  // Pixel stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // pixel_x[8:0], pixel_y[17:9], zero pad
  output logic              out_tlast,  // last_out
  output logic              out_tuser   // hit
);

  queue_stat_t q_stat;
  work_t       push_item, q_head;
  logic        push, pop;

  pstp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  pstp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  pstp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_head     (q_head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // The queue never overfills and is never drained past empty.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from an empty queue");

  // A miss always reports the origin pixel.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("miss carries nonzero coordinates");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pstp_pkg::*;

  localparam int PIPE_LATENCY    = 4 + 2 + CORDIC_STAGES;
  localparam int IDLE_LIMIT      = 4000;
  localparam int LONG_HOLD       = 400;
  localparam int RX_MODE_PERIOD  = 97;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 95;
  localparam int HOLD_PHASE      = 2;
  localparam int PAUSE_PHASE     = 6;
  localparam int DIRECTED_ROWS   = 36;
  localparam int REPORT_LIMIT    = 10;

  // An index past the last register; writes to it must change nothing.
  localparam logic [CFG_AW-1:0] CFG_SPARE = 3'd5;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_RHYTHM, RX_SPARSE} rx_mode_t;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic             hit;
    logic             last;
  } pixel_result_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [CFG_AW-1:0] addr;
    logic [CFG_DW-1:0] data;
    logic [15:0]       range_mm;
    logic [11:0]       beam;
    logic              last;
    logic              pinned;
    pixel_result_t     pin;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic              out_tlast;
  logic              out_tuser;

  // Shadow copy of the block's registers, at their reset values.
  bit [15:0] gate_lo = 16'd0;
  bit [15:0] gate_hi = 16'hFFFF;
  bit [15:0] angle_base = 16'd0;
  bit [15:0] angle_incr = 16'd0;
  bit [23:0] scale = 24'd1365;

  pixel_result_t pending_pixels[$];
  stim_row_t     directed_rows[DIRECTED_ROWS];
  int            mismatch_count = 0;
  int            idle_cycles = 0;

  // Side band from the sender: a result typed into the directed table.
  bit            pin_valid = 1'b0;
  pixel_result_t pin_value = '0;

  // Sender burst state.
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;

  // Receiver state.
  bit          long_hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned rx_tick = 0;
  rx_mode_t    rx_mode = RX_ALWAYS;

  polar_scan_to_pixel_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // Arctangent of 2^-stage as a fraction of a turn, scaled by 2^32.
  function automatic longint atan_turn(int stage);
    case (stage)
      0:  return 'h20000000;
      1:  return 'h12E4051E;
      2:  return 'h09FB385B;
      3:  return 'h051111D4;
      4:  return 'h028B0D43;
      5:  return 'h0145D7E1;
      6:  return 'h00A2F61E;
      7:  return 'h00517C55;
      8:  return 'h0028BE53;
      9:  return 'h00145F2F;
      10: return 'h000A2F98;
      11: return 'h000517CC;
      12: return 'h00028BE6;
      13: return 'h000145F3;
      14: return 'h0000A2F9;
      15: return 'h0000517C;
      16: return 'h000028BE;
      17: return 'h0000145F;
      18: return 'h00000A2F;
      19: return 'h00000517;
      20: return 'h0000028B;
      21: return 'h00000145;
      22: return 'h000000A2;
      23: return 'h00000051;
      default: return 0;
    endcase
  endfunction

  // Projects one sample onto the image using the shadow registers.
  function automatic pixel_result_t project_sample(bit [15:0] range_mm, bit [11:0] beam,
                                                   bit last);
    pixel_result_t r;
    bit [15:0]     theta;
    bit            flip;
    longint        a, x, y, z, xs, ys, c, s, rs, xi, yi;
    r = '0;
    r.last = last;
    if (range_mm > gate_lo && range_mm < gate_hi && beam < BEAM_COUNT) begin
      theta = angle_base + beam * angle_incr;
      a = longint'($signed(theta));
      flip = 1'b0;
      // Fold into a half turn around zero; the far side comes back negated.
      if (a > 16384) begin
        a -= 32768;
        flip = 1'b1;
      end else if (a < -16384) begin
        a += 32768;
        flip = 1'b1;
      end
      z = a * 65536;
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys;
          y += xs;
          z -= atan_turn(i);
        end else begin
          x += ys;
          y -= xs;
          z += atan_turn(i);
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = (x + 512) >>> 10;
      s = (y + 512) >>> 10;
      rs = longint'(range_mm) * longint'(scale);
      // Signed division truncates toward zero.
      xi = (rs * c) / (longint'(1) <<< 36) + IMAGE_SIZE / 2;
      yi = (rs * s) / (longint'(1) <<< 36) + IMAGE_SIZE / 2;
      if (xi >= 0 && xi < IMAGE_SIZE && yi >= 0 && yi < IMAGE_SIZE) begin
        r.x = xi[PIX_W-1:0];
        r.y = yi[PIX_W-1:0];
        r.hit = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic stim_row_t item_row(bit [15:0] range_mm, bit [11:0] beam, bit last);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.range_mm = range_mm;
    row.beam = beam;
    row.last = last;
    return row;
  endfunction

  function automatic stim_row_t pinned_row(bit [15:0] range_mm, bit [11:0] beam, bit last,
                                           bit [PIX_W-1:0] x, bit [PIX_W-1:0] y, bit hit);
    stim_row_t row;
    row = item_row(range_mm, beam, last);
    row.pinned = 1'b1;
    row.pin.x = x;
    row.pin.y = y;
    row.pin.hit = hit;
    row.pin.last = last;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.addr = addr;
    row.data = data;
    return row;
  endfunction

  // A range inside the current gate when one exists.
  function automatic bit [15:0] gated_range();
    if (int'(gate_hi) > int'(gate_lo) + 1)
      return 16'($urandom_range(int'(gate_lo) + 1, int'(gate_hi) - 1));
    return 16'($urandom);
  endfunction

  task automatic write_register(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stop offering items and wait until every result has come out.
  task automatic settle_pipeline();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  // Offers one item, with a random gap at the start of each burst while gaps are on.
  task automatic send_sample(bit [15:0] range_mm, bit [11:0] beam, bit last,
                             bit pinned, pixel_result_t pin);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, beam, range_mm};
    in_tlast <= last;
    pin_valid = pinned;
    pin_value = pin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Random register settings; the scale mostly fits the range limit to the image.
  task automatic choose_settings(int phase);
    int unsigned top, bottom, pix, beams;
    bit [15:0]   step;
    top = $urandom_range(300, 65535);
    bottom = $urandom_range(0, top / 3);
    pix = (IMAGE_SIZE * 65536) / (2 * top);
    pix = pix * $urandom_range(80, 130) / 100;
    if (phase % 3 == 0)
      pix = $urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 16);
    beams = $urandom_range(8, 4096);
    step = 16'(65536 / beams);
    if ($urandom_range(0, 1) == 1)
      step = -step;
    if ($urandom_range(0, 3) == 0)
      step = 16'($urandom);
    write_register(CFG_RANGE_MIN, CFG_DW'(bottom));
    write_register(CFG_RANGE_MAX, CFG_DW'(top));
    write_register(CFG_ANGLE_START, CFG_DW'($urandom_range(0, 16'hFFFF)));
    write_register(CFG_ANGLE_STEP, CFG_DW'(step));
    write_register(CFG_PIXEL_SCALE, CFG_DW'(pix));
    if ($urandom_range(0, 3) == 0)
      write_register(CFG_SPARE, CFG_DW'($urandom));
  endtask

  // Track register writes the block sees.
  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      case (cfg_addr)
        CFG_RANGE_MIN:   gate_lo = cfg_wdata[15:0];
        CFG_RANGE_MAX:   gate_hi = cfg_wdata[15:0];
        CFG_ANGLE_START: angle_base = cfg_wdata[15:0];
        CFG_ANGLE_STEP:  angle_incr = cfg_wdata[15:0];
        CFG_PIXEL_SCALE: scale = cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // Every accepted item queues the result it must produce.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      if (pin_valid)
        pending_pixels.insert(pending_pixels.size(), pin_value);
      else
        pending_pixels.insert(pending_pixels.size(),
                              project_sample(in_tdata[15:0], in_tdata[27:16], in_tlast));
    end
  end

  // Compare every accepted result with the oldest pending one.
  always @(posedge clk) begin
    pixel_result_t want;
    pixel_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.x = out_tdata[8:0];
      got.y = out_tdata[17:9];
      got.hit = out_tuser;
      got.last = out_tlast;
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result x=%0d y=%0d hit=%0b last=%0b",
                   got.x, got.y, got.hit, got.last);
      end else begin
        want = pending_pixels.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.hit !== want.hit ||
            got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch: expected x=%0d y=%0d hit=%0b last=%0b,",
                     want.x, want.y, want.hit, want.last,
                     " got x=%0d y=%0d hit=%0b last=%0b",
                     got.x, got.y, got.hit, got.last);
        end
      end
    end
  end

  // Receiver: one long hold on request, otherwise a changing stall pattern.
  always @(negedge clk) begin
    rx_tick++;
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_RHYTHM: out_tready <= (rx_tick % 5) != 0;
        RX_SPARSE: out_tready <= $urandom_range(0, 7) == 0;
        default:   out_tready <= 1'b1;
      endcase
    end
    if (rx_tick % RX_MODE_PERIOD == 0)
      rx_mode = rx_mode_t'($urandom_range(0, 3));
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned   sent, scan_len, first_beam;
    bit [15:0]     range_mm;
    bit [11:0]     beam;
    bit            broken, paused;
    pixel_result_t none;
    none = '0;

    // Directed table: extremes, quadrant folds, angle wrap, gating, spare index.
    directed_rows = '{
      pinned_row(16'd0, 12'd0, 1'b0, 9'd0, 9'd0, 1'b0),
      pinned_row(16'hFFFF, 12'hFFF, 1'b1, 9'd0, 9'd0, 1'b0),
      pinned_row(16'd1, 12'd0, 1'b0, 9'd250, 9'd250, 1'b1),
      pinned_row(16'hFFFE, 12'd0, 1'b1, 9'd0, 9'd0, 1'b0),
      item_row(16'd100, 12'hFFF, 1'b0),
      cfg_row(CFG_PIXEL_SCALE, 24'h010000),
      cfg_row(CFG_ANGLE_STEP, 24'd16),
      item_row(16'd200, 12'd0, 1'b0),
      item_row(16'd200, 12'd1024, 1'b0),
      item_row(16'd200, 12'd1023, 1'b0),
      item_row(16'd200, 12'd1025, 1'b0),
      item_row(16'd249, 12'd0, 1'b0),
      item_row(16'd251, 12'd2048, 1'b0),
      item_row(16'd200, 12'd3072, 1'b1),
      cfg_row(CFG_ANGLE_START, 24'h008000),
      cfg_row(CFG_ANGLE_STEP, 24'h007FFF),
      item_row(16'd150, 12'd1, 1'b0),
      item_row(16'd150, 12'hFFF, 1'b1),
      cfg_row(CFG_ANGLE_STEP, 24'h008000),
      cfg_row(CFG_ANGLE_START, 24'h007FFF),
      item_row(16'd150, 12'd3, 1'b0),
      cfg_row(CFG_RANGE_MIN, 24'd1000),
      cfg_row(CFG_RANGE_MAX, 24'd1001),
      pinned_row(16'd1000, 12'd0, 1'b0, 9'd0, 9'd0, 1'b0),
      pinned_row(16'd1001, 12'd0, 1'b1, 9'd0, 9'd0, 1'b0),
      cfg_row(CFG_SPARE, 24'hFFFFFF),
      cfg_row(CFG_RANGE_MIN, 24'h00FFFF),
      cfg_row(CFG_RANGE_MAX, 24'd0),
      pinned_row(16'd500, 12'd5, 1'b0, 9'd0, 9'd0, 1'b0),
      cfg_row(CFG_RANGE_MIN, 24'd0),
      cfg_row(CFG_RANGE_MAX, 24'h00FFFF),
      cfg_row(CFG_PIXEL_SCALE, 24'hFFFFFF),
      item_row(16'd1, 12'd0, 1'b0),
      item_row(16'd1, 12'd512, 1'b0),
      cfg_row(CFG_PIXEL_SCALE, 24'd0),
      pinned_row(16'd40000, 12'd77, 1'b1, 9'd250, 9'd250, 1'b1)
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        settle_pipeline();
        write_register(directed_rows[r].addr, directed_rows[r].data);
      end else begin
        send_sample(directed_rows[r].range_mm, directed_rows[r].beam, directed_rows[r].last,
                    directed_rows[r].pinned, directed_rows[r].pin);
      end
    end

    // Random phases: mostly whole scans with in-gate ranges, some noise.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_pipeline();
      choose_settings(phase);
      gaps_on = (phase % 4) != 1;
      if (phase == HOLD_PHASE)
        long_hold_req = 1'b1;
      sent = 0;
      paused = 1'b0;
      while (sent < ITEMS_PER_PHASE) begin
        if (phase == PAUSE_PHASE && !paused && sent >= ITEMS_PER_PHASE / 2) begin
          settle_pipeline();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 2) begin
          send_sample(16'($urandom), 12'($urandom), 1'($urandom_range(0, 1)), 1'b0, none);
          sent++;
        end else begin
          scan_len = $urandom_range(4, 48);
          // A scan never runs past the phase's share of items.
          if (scan_len > ITEMS_PER_PHASE - sent)
            scan_len = ITEMS_PER_PHASE - sent;
          first_beam = $urandom_range(0, 4095);
          broken = $urandom_range(0, 9) == 0;
          for (int k = 0; k < scan_len; k++) begin
            beam = 12'(first_beam + k);
            range_mm = ($urandom_range(0, 19) < 17) ? gated_range() : 16'($urandom);
            send_sample(range_mm, beam, (k == scan_len - 1) && !broken, 1'b0, none);
            sent++;
          end
        end
      end
    end

    settle_pipeline();
    if (mismatch_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

// File: sim.f
sv/pstp_pkg.sv
sv/pstp_front.sv
sv/pstp_queue.sv
sv/pstp_back.sv
sv/polar_scan_to_pixel_core.sv
tb/testbench.sv
